// ----- sv/bpi_pkg.sv -----
// ----------------------------------------------------------------------------
// bpi_pkg
// Shared types, constants and helper functions of the palette interpolator.
// ----------------------------------------------------------------------------
package bpi_pkg;

  localparam int unsigned MAX_INDEX_BITS = 4;
  localparam int unsigned CapBits = (MAX_INDEX_BITS < 2) ? 2 :
                                    (MAX_INDEX_BITS > 4) ? 4 : MAX_INDEX_BITS;

  localparam logic [2:0] MODE_FOUR  = 3'd0;
  localparam logic [2:0] MODE_THREE = 3'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [9:0] RECIP_THREE  = 10'd683;   // ceil(2^11 / 3)
  localparam int unsigned RecipShift  = 11;
  localparam logic [14:0] ROUND_HALF  = 15'd32;
  localparam int unsigned WeightShift = 6;

  typedef logic [3:0][7:0] rgba_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [3:0] idx;
    logic       last;
  } bpi_cmd_t;

  typedef struct packed {
    logic out_free;
  } bpi_sts_t;

  typedef logic [15:0][6:0] weight_row_t;

  localparam weight_row_t WEIGHTS_2 = {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                                       7'd0, 7'd0, 7'd0, 7'd0, 7'd64, 7'd43, 7'd21, 7'd0};
  localparam weight_row_t WEIGHTS_3 = {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
                                       7'd64, 7'd55, 7'd46, 7'd37, 7'd27, 7'd18, 7'd9, 7'd0};
  localparam weight_row_t WEIGHTS_4 = {7'd64, 7'd60, 7'd55, 7'd51, 7'd47, 7'd43, 7'd38,
                                       7'd34, 7'd30, 7'd26, 7'd21, 7'd17, 7'd13, 7'd9,
                                       7'd4, 7'd0};

  // index bits of a weighted mode, saturated to the cap
  function automatic logic [2:0] index_bits(input logic [2:0] mode);
    logic [2:0] cap;
    cap = 3'(CapBits);
    return (mode > cap) ? cap : mode;
  endfunction

  function automatic logic [3:0] last_index(input logic [2:0] mode);
    logic [2:0] bits;
    bits = index_bits(mode);
    if (mode == MODE_FOUR || mode == MODE_THREE) begin
      return 4'd3;
    end
    return 4'((5'd1 << bits) - 5'd1);
  endfunction

  function automatic logic [6:0] weight(input logic [2:0] bits, input logic [3:0] idx);
    logic [6:0] w;
    case (bits)
      3'd2:    w = WEIGHTS_2[idx];
      3'd3:    w = WEIGHTS_3[idx];
      3'd4:    w = WEIGHTS_4[idx];
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/bpi_if.sv -----
// ----------------------------------------------------------------------------
// bpi_if
// Valid/ready channels for endpoint input and palette entry output.
// ----------------------------------------------------------------------------
interface bpi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] palette_mode;
  logic [7:0] start_red;
  logic [7:0] start_green;
  logic [7:0] start_blue;
  logic [7:0] start_alpha;
  logic [7:0] end_red;
  logic [7:0] end_green;
  logic [7:0] end_blue;
  logic [7:0] end_alpha;

  modport source (
    output valid, palette_mode, start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    input  ready
  );
  modport sink (
    input  valid, palette_mode, start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    output ready
  );
endinterface

interface bpi_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] entry_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       last_entry;

  modport source (
    output valid, entry_index, out_red, out_green, out_blue, out_alpha, last_entry,
    input  ready
  );
  modport sink (
    input  valid, entry_index, out_red, out_green, out_blue, out_alpha, last_entry,
    output ready
  );
endinterface

// ----- sv/block_palette_interpolator_core.sv -----
// The first palette entry is registered after the sequencer enters its run state.
// Throughput: one entry per cycle from the shared blend unit while the output
// is not stalled; an item holds n entries (n = 4, 8 or 16).
// A new input is taken once the last entry of the previous one is registered.
// Reset: asynchronous active low; clears sequencer state and output valid.
// ----------------------------------------------------------------------------
// block_palette_interpolator_core
// Expands two RGBA8 endpoints into a BC1/BC7 style palette, one entry per
// output transaction.
// ----------------------------------------------------------------------------
module block_palette_interpolator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpi_in_if.sink     in_i,
  bpi_out_if.source  out_o
);

  bpi_pkg::bpi_cmd_t cmd;
  bpi_pkg::bpi_sts_t sts;
  bpi_pkg::rgba_t    in_start, in_end, out_rgba;

  assign in_start = {in_i.start_alpha, in_i.start_blue, in_i.start_green, in_i.start_red};
  assign in_end   = {in_i.end_alpha, in_i.end_blue, in_i.end_green, in_i.end_red};

  bpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.palette_mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpi_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (in_i.palette_mode),
    .in_start_i  (in_start),
    .in_end_i    (in_end),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_index_o (out_o.entry_index),
    .out_rgba_o  (out_rgba),
    .out_last_o  (out_o.last_entry)
  );

  assign out_o.out_red   = out_rgba[0];
  assign out_o.out_green = out_rgba[1];
  assign out_o.out_blue  = out_rgba[2];
  assign out_o.out_alpha = out_rgba[3];

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while palette in progress");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_entry) |->
      (out_o.entry_index == 4'd3 || out_o.entry_index == 4'd7 ||
       out_o.entry_index == 4'd15))
    else $error("last entry at wrong palette index");

  a_first_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> (out_o.entry_index == 4'd0))
    else $error("palette did not start at entry zero");
`endif

endmodule

// ----- sv/bpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpi_ctrl
// Sequencer: accepts one endpoint pair and steps through its palette entries.
// ----------------------------------------------------------------------------
module bpi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_mode_i,
  output logic              in_ready_o,
  input  bpi_pkg::bpi_sts_t sts_i,
  output bpi_pkg::bpi_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0] last_q, last_d;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.load = in_valid_i && (state_q == ST_IDLE);
    cmd_o.emit = (state_q == ST_RUN) && sts_i.out_free;
    cmd_o.idx  = cnt_q;
    cmd_o.last = (cnt_q == last_q);

    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          cnt_d   = 4'd0;
          last_d  = bpi_pkg::last_index(in_mode_i);
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          if (cnt_q == last_q) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 4'd0;
      last_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

endmodule

// ----- sv/bpi_datapath.sv -----
// ----------------------------------------------------------------------------
// bpi_datapath
// Endpoint hold registers, shared blend unit and palette entry output register.
// ----------------------------------------------------------------------------
module bpi_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpi_pkg::bpi_cmd_t cmd_i,
  output bpi_pkg::bpi_sts_t sts_o,
  input  logic [2:0]        in_mode_i,
  input  bpi_pkg::rgba_t    in_start_i,
  input  bpi_pkg::rgba_t    in_end_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [3:0]        out_index_o,
  output bpi_pkg::rgba_t    out_rgba_o,
  output logic              out_last_o
);

  logic [2:0]     mode_q;
  bpi_pkg::rgba_t start_q, end_q;
  logic           valid_q, valid_d;
  logic [3:0]     index_q;
  bpi_pkg::rgba_t rgba_q, rgba_d;
  logic           last_q;

  logic [2:0]  bits;
  logic [3:0]  top_idx;
  logic [6:0]  w_hi, w_lo;
  logic [9:0]  sum3 [4];
  logic [19:0] prod3 [4];
  logic [8:0]  sum2 [4];
  logic [14:0] blend [4];

  assign sts_o.out_free = !valid_q || out_ready_i;

  always_comb begin
    bits    = bpi_pkg::index_bits(mode_q);
    top_idx = bpi_pkg::last_index(mode_q);
    w_hi    = bpi_pkg::weight(bits, cmd_i.idx);
    w_lo    = bpi_pkg::weight(bits, top_idx - cmd_i.idx);
    for (int c = 0; c < 4; c++) begin
      if (cmd_i.idx[0]) begin
        sum3[c] = {2'b00, start_q[c]} + {1'b0, end_q[c], 1'b0};
      end else begin
        sum3[c] = {1'b0, start_q[c], 1'b0} + {2'b00, end_q[c]};
      end
      prod3[c] = 20'(sum3[c]) * 20'(bpi_pkg::RECIP_THREE);
      sum2[c]  = {1'b0, start_q[c]} + {1'b0, end_q[c]};
      blend[c] = 15'(w_lo) * 15'(start_q[c]) + 15'(w_hi) * 15'(end_q[c])
               + bpi_pkg::ROUND_HALF;
    end

    case (mode_q)
      bpi_pkg::MODE_FOUR: begin
        for (int c = 0; c < 4; c++) begin
          rgba_d[c] = 8'(prod3[c] >> bpi_pkg::RecipShift);
        end
        rgba_d[3] = bpi_pkg::ALPHA_OPAQUE;
      end
      bpi_pkg::MODE_THREE: begin
        if (cmd_i.idx[0]) begin
          rgba_d = '0;
        end else begin
          for (int c = 0; c < 4; c++) begin
            rgba_d[c] = sum2[c][8:1];
          end
          rgba_d[3] = bpi_pkg::ALPHA_OPAQUE;
        end
      end
      default: begin
        for (int c = 0; c < 4; c++) begin
          rgba_d[c] = 8'(blend[c] >> bpi_pkg::WeightShift);
        end
      end
    endcase

    // endpoints pass through in the four- and three-color modes
    if (mode_q == bpi_pkg::MODE_FOUR || mode_q == bpi_pkg::MODE_THREE) begin
      if (cmd_i.idx == 4'd0) begin
        rgba_d = start_q;
      end else if (cmd_i.idx == 4'd1) begin
        rgba_d = end_q;
      end
    end

    valid_d = valid_q;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
      index_q <= '0;
      rgba_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        mode_q  <= in_mode_i;
        start_q <= in_start_i;
        end_q   <= in_end_i;
      end
      if (cmd_i.emit) begin
        index_q <= cmd_i.idx;
        rgba_q  <= rgba_d;
        last_q  <= cmd_i.last;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_index_o = index_q;
  assign out_rgba_o  = rgba_q;
  assign out_last_o  = last_q;

endmodule

// ----- bench/block_palette_interpolator_core_tb.sv -----
// ----------------------------------------------------------------------------
// block_palette_interpolator_core_tb
// Self-checking bench for the palette interpolator. Sends endpoint pairs in
// every palette mode, predicts the full palette for each transaction and
// compares each output entry in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module block_palette_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned MAX_WAIT     = 11;
  localparam int unsigned RANDOM_ITEMS = 230;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [2:0] MODE_W2  = 3'd2;
  localparam logic [2:0] MODE_W3  = 3'd3;
  localparam logic [2:0] MODE_W4  = 3'd4;
  localparam logic [2:0] MODE_MAX = 3'd7;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  localparam int unsigned BLEND_W2 [16] = '{0, 21, 43, 64, 0, 0, 0, 0,
                                            0, 0, 0, 0, 0, 0, 0, 0};
  localparam int unsigned BLEND_W3 [16] = '{0, 9, 18, 27, 37, 46, 55, 64,
                                            0, 0, 0, 0, 0, 0, 0, 0};
  localparam int unsigned BLEND_W4 [16] = '{0, 4, 9, 13, 17, 21, 26, 30,
                                            34, 38, 43, 47, 51, 55, 60, 64};

  typedef struct packed {
    logic [3:0]     idx;
    bpi_pkg::rgba_t color;
    logic           last;
  } palette_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpi_in_if  endpoint_ch ();
  bpi_out_if entry_ch ();

  block_palette_interpolator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (endpoint_ch.sink),
    .out_o  (entry_ch.source)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  palette_entry_t palette_q[$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;
  bit             no_idle = 1'b0;

  function automatic int unsigned draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic int unsigned blend_weight(input int unsigned bits, input int unsigned k);
    case (bits)
      2:       return BLEND_W2[k];
      3:       return BLEND_W3[k];
      default: return BLEND_W4[k];
    endcase
  endfunction

  // expected palette of one request, appended to palette_q
  function automatic void predict_palette(input logic [2:0] mode,
                                          input bpi_pkg::rgba_t s,
                                          input bpi_pkg::rgba_t e);
    int unsigned    cap, bits, n, j, ch, acc;
    palette_entry_t ent;
    bpi_pkg::rgba_t mix;
    cap = bpi_pkg::MAX_INDEX_BITS;
    if (cap < 2) cap = 2;
    if (cap > 4) cap = 4;
    if (mode == bpi_pkg::MODE_FOUR || mode == bpi_pkg::MODE_THREE) begin
      palette_q.push_back('{idx: 4'd0, color: s, last: 1'b0});
      palette_q.push_back('{idx: 4'd1, color: e, last: 1'b0});
      if (mode == bpi_pkg::MODE_FOUR) begin
        for (ch = CH_RED; ch <= CH_BLUE; ch++) mix[ch] = 8'((2 * s[ch] + e[ch]) / 3);
        mix[CH_ALPHA] = bpi_pkg::ALPHA_OPAQUE;
        palette_q.push_back('{idx: 4'd2, color: mix, last: 1'b0});
        for (ch = CH_RED; ch <= CH_BLUE; ch++) mix[ch] = 8'((s[ch] + 2 * e[ch]) / 3);
        palette_q.push_back('{idx: 4'd3, color: mix, last: 1'b1});
      end else begin
        for (ch = CH_RED; ch <= CH_BLUE; ch++) mix[ch] = 8'((s[ch] + e[ch]) / 2);
        mix[CH_ALPHA] = bpi_pkg::ALPHA_OPAQUE;
        palette_q.push_back('{idx: 4'd2, color: mix, last: 1'b0});
        palette_q.push_back('{idx: 4'd3, color: '0, last: 1'b1});
      end
    end else begin
      bits = (mode > cap) ? cap : mode;
      n = 1 << bits;
      j = n - 1;
      for (int unsigned i = 0; i < n; i++) begin
        if (i == 0) begin
          mix = s;
        end else if (i == j) begin
          mix = e;
        end else begin
          for (ch = CH_RED; ch <= CH_ALPHA; ch++) begin
            acc = blend_weight(bits, j - i) * s[ch] + blend_weight(bits, i) * e[ch] + 32;
            mix[ch] = 8'(acc >> 6);
          end
        end
        ent.idx   = 4'(i);
        ent.color = mix;
        ent.last  = (i == j);
        palette_q.push_back(ent);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // one request transaction; valid stays high until the next gap
  task automatic send_request(input logic [2:0] mode, input bpi_pkg::rgba_t s,
                              input bpi_pkg::rgba_t e);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      endpoint_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    endpoint_ch.valid        <= 1'b1;
    endpoint_ch.palette_mode <= mode;
    endpoint_ch.start_red    <= s[CH_RED];
    endpoint_ch.start_green  <= s[CH_GREEN];
    endpoint_ch.start_blue   <= s[CH_BLUE];
    endpoint_ch.start_alpha  <= s[CH_ALPHA];
    endpoint_ch.end_red      <= e[CH_RED];
    endpoint_ch.end_green    <= e[CH_GREEN];
    endpoint_ch.end_blue     <= e[CH_BLUE];
    endpoint_ch.end_alpha    <= e[CH_ALPHA];
    do @(posedge clk_i); while (!endpoint_ch.ready);
    predict_palette(mode, s, e);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bpi_pkg::rgba_t rand_color();
    bpi_pkg::rgba_t c;
    for (int ch = CH_RED; ch <= CH_ALPHA; ch++) c[ch] = rand_channel();
    return c;
  endfunction

  task automatic test_endpoint_extremes();
    for (logic [3:0] m = bpi_pkg::MODE_FOUR; m <= MODE_W4; m++) begin
      send_request(m[2:0], '0, '1);
      send_request(m[2:0], '1, '0);
    end
  endtask

  task automatic test_uniform_endpoints();
    send_request(bpi_pkg::MODE_FOUR, '0, '0);
    send_request(bpi_pkg::MODE_THREE, '1, '1);
    send_request(MODE_W3, {4{8'haa}}, {4{8'h55}});
    send_request(bpi_pkg::MODE_THREE, {4{8'h55}}, {4{8'haa}});
  endtask

  task automatic test_saturated_modes();
    for (logic [3:0] m = 4'(MODE_W4) + 4'd1; m <= MODE_MAX; m++) begin
      send_request(m[2:0], rand_color(), rand_color());
    end
  endtask

  task automatic test_random_palettes();
    logic [2:0]     mode;
    bpi_pkg::rgba_t s, e;
    int unsigned    r;
    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = ((k / 40) % 3 == 2);
      r = $urandom_range(0, 10);
      mode = (r > MODE_MAX) ?
             3'($urandom_range(bpi_pkg::MODE_FOUR, bpi_pkg::MODE_THREE)) : 3'(r);
      s = rand_color();
      case ($urandom_range(0, 4))
        0:       e = s;
        1: begin
          e = s;
          e[$urandom_range(CH_RED, CH_ALPHA)] ^= 8'(1 << $urandom_range(0, 7));
        end
        default: e = rand_color();
      endcase
      send_request(mode, s, e);
    end
    no_idle = 1'b0;
  endtask

  initial begin : entry_sink
    int unsigned stall;
    entry_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        entry_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      entry_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && entry_ch.valid));
    end
  end

  always @(posedge clk_i) begin : entry_check
    palette_entry_t want;
    if (rst_ni && entry_ch.valid && entry_ch.ready) begin
      if (palette_q.size() == 0) begin
        report_mismatch("unexpected entry index", entry_ch.entry_index, -1);
      end else begin
        want = palette_q.pop_front();
        if (entry_ch.entry_index !== want.idx)
          report_mismatch("entry_index", entry_ch.entry_index, want.idx);
        if (entry_ch.out_red !== want.color[CH_RED])
          report_mismatch("out_red", entry_ch.out_red, want.color[CH_RED]);
        if (entry_ch.out_green !== want.color[CH_GREEN])
          report_mismatch("out_green", entry_ch.out_green, want.color[CH_GREEN]);
        if (entry_ch.out_blue !== want.color[CH_BLUE])
          report_mismatch("out_blue", entry_ch.out_blue, want.color[CH_BLUE]);
        if (entry_ch.out_alpha !== want.color[CH_ALPHA])
          report_mismatch("out_alpha", entry_ch.out_alpha, want.color[CH_ALPHA]);
        if (entry_ch.last_entry !== want.last)
          report_mismatch("last_entry", entry_ch.last_entry, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries pending", cycle_count,
               palette_q.size());
      $display("block_palette_interpolator_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni                   <= 1'b0;
    endpoint_ch.valid        <= 1'b0;
    endpoint_ch.palette_mode <= bpi_pkg::MODE_FOUR;
    endpoint_ch.start_red    <= '0;
    endpoint_ch.start_green  <= '0;
    endpoint_ch.start_blue   <= '0;
    endpoint_ch.start_alpha  <= '0;
    endpoint_ch.end_red      <= '0;
    endpoint_ch.end_green    <= '0;
    endpoint_ch.end_blue     <= '0;
    endpoint_ch.end_alpha    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_endpoint_extremes();
    test_uniform_endpoints();
    test_saturated_modes();
    test_random_palettes();

    endpoint_ch.valid <= 1'b0;
    while (palette_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("block_palette_interpolator_core regression: pass");
    end else begin
      $display("block_palette_interpolator_core regression: fail");
    end
    $finish;
  end

endmodule
